### design/fpst_pkg.sv
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared types and constants of the Fenwick prefix-sum table core.
// ----------------------------------------------------------------------------
package fpst_pkg;

	localparam int ENT_W  = 11;
	localparam int POS_W  = 10;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_SET   = 2'd1,
		OP_QUERY = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t                      opcode;
		logic [POS_W-1:0]         position;
		logic [POS_W-1:0]         range_low;
		logic signed [DATA_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sum;
		logic                     index_error;
	} res_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_WALK_A = 8'b0000_0010,
		ST_WALK_B = 8'b0000_0100,
		ST_DRAIN  = 8'b0000_1000,
		ST_CALC   = 8'b0001_0000,
		ST_UPD    = 8'b0010_0000,
		ST_CLR    = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

endpackage

### design/fenwick_prefix_sum_table_core.sv
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table_core
// Binary indexed tree over signed 32-bit counts: add, set, range sum, clear.
// ----------------------------------------------------------------------------
//  channel   | dir | fields (low bit up)
//  s_axis    | in  | tdata: position, range_low, amount; tuser: opcode
//  m_axis    | out | tdata: sum; tuser: index_error
//  cfg       | in  | wr_data: entries_in_use
//
// One item at a time, bound by the node RAM read port (one node per cycle).
// Add: an update walk up the tree; query: two prefix walks, subtracted; set:
// a point read plus an add walk. Clear: a sweep over all MAX_ENTRIES nodes.
// After reset a clear sweep runs before the first item.
// A result held in the output register lets one more item in; that item's
// result then waits in the sequencer and holds off the input until it drains.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_core
	import fpst_pkg::*;
#(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [55:0]       s_axis_tdata,   // position, range_low, amount, pad
	input  logic [1:0]        s_axis_tuser,   // opcode
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [31:0]       m_axis_tdata,   // sum
	output logic [0:0]        m_axis_tuser,   // index_error
	input  logic              cfg_wr_en,
	input  logic [ENT_W-1:0]  cfg_wr_data
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam logic [ENT_W-1:0] ENT_SAT   = (MAX_ENTRIES > 2047) ? 11'd2047 :
	                                         ENT_W'(MAX_ENTRIES);
	localparam logic [ENT_W-1:0] ENT_RESET = (MAX_ENTRIES > 1024) ? 11'd1024 :
	                                         ENT_W'(MAX_ENTRIES);

	logic [ENT_W-1:0]  entries_q;
	logic              out_valid_q;
	res_t              out_q;
	req_t              req;
	res_t              res;
	logic              res_valid;
	logic              res_ready;
	logic              start;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	always_comb begin
		req.opcode    = op_t'(s_axis_tuser);
		req.position  = s_axis_tdata[9:0];
		req.range_low = s_axis_tdata[19:10];
		req.amount    = $signed(s_axis_tdata[51:20]);
		start         = s_axis_tvalid && s_axis_tready;
		res_ready     = !out_valid_q || m_axis_tready;
		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = out_q.sum;
		m_axis_tuser  = out_q.index_error;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q   <= ENT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				entries_q <= (cfg_wr_data > ENT_SAT) ? ENT_SAT : cfg_wr_data;
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	fpst_walk_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.AW         (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.ready    (s_axis_tready),
		.entries  (entries_q),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	fpst_node_ram #(
		.DEPTH(MAX_ENTRIES),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	a_err_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("flagged result carries a nonzero sum");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again while an item is in work");

	a_bound_sat: assert property (@(posedge clk) disable iff (!arst_n)
		entries_q <= ENT_SAT)
		else $error("entry bound above table size");

endmodule

### design/fpst_node_ram.sv
// ----------------------------------------------------------------------------
// fpst_node_ram
// Simple dual-port node store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fpst_node_ram
	import fpst_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/fpst_walk_ctrl.sv
// ----------------------------------------------------------------------------
// fpst_walk_ctrl
// Sequencer for node walks: prefix reads, read-modify-write update, clear sweep.
// ----------------------------------------------------------------------------
module fpst_walk_ctrl
	import fpst_pkg::*;
#(
	parameter int MAX_ENTRIES = 1024,
	parameter int AW          = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              req,
	output logic              ready,
	input  logic [ENT_W-1:0]  entries,
	input  logic              res_ready,
	output logic              res_valid,
	output res_t              res,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [DATA_W-1:0] wr_data,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  logic [DATA_W-1:0] rd_data
);

	localparam int NB = $clog2(MAX_ENTRIES + 1);
	localparam int NW = ((NB > ENT_W) ? NB : ENT_W) + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);

	state_t            state_q;
	logic [NW-1:0]     node_q;
	logic [AW-1:0]     clr_q;
	logic              item_q;
	logic              pend_s1;
	logic              upd_s1;
	logic              neg_s1;
	logic [AW-1:0]     waddr_s1;
	req_t              req_q;
	logic              err_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] delta_q;

	logic [NW-1:0]     lowbit;
	logic [NW-1:0]     node_dn;
	logic [NW-1:0]     node_up;
	logic [NW-1:0]     start_a;
	logic [NW-1:0]     start_b;
	logic              in_err;
	logic              upd_live;
	logic [DATA_W-1:0] diff;

	always_comb begin
		lowbit   = node_q & (~node_q + NW'(1));
		node_dn  = node_q - lowbit;
		node_up  = node_q + lowbit;
		start_a  = NW'(req_q.position) + NW'(1);
		start_b  = (req_q.opcode == OP_QUERY) ? NW'(req_q.range_low) : NW'(req_q.position);
		upd_live = node_q <= NW'(entries);
		diff     = DATA_W'(req_q.amount) - acc_q;
		in_err   = ({1'b0, req.position} >= entries) ||
		           ((req.opcode == OP_QUERY) && ({1'b0, req.range_low} >= entries));
		rd_addr  = AW'(node_q - NW'(1));
		rd_en    = (state_q == ST_WALK_A) || (state_q == ST_WALK_B) ||
		           ((state_q == ST_UPD) && upd_live);
		wr_en    = upd_s1 || (state_q == ST_CLR);
		wr_addr  = (state_q == ST_CLR) ? clr_q : waddr_s1;
		wr_data  = (state_q == ST_CLR) ? '0 : rd_data + delta_q;
		ready    = state_q == ST_IDLE;
		res_valid       = (state_q == ST_DONE) && res_ready;
		res.sum         = (req_q.opcode == OP_QUERY) ? $signed(acc_q) : '0;
		res.index_error = err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			node_q  <= '0;
			clr_q   <= '0;
			item_q  <= 1'b0;
			pend_s1 <= 1'b0;
			upd_s1  <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_WALK_A) || (state_q == ST_WALK_B);
			upd_s1  <= (state_q == ST_UPD) && upd_live;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q <= 1'b1;
						node_q <= NW'(req.position) + NW'(1);
						clr_q  <= '0;
						if (req.opcode == OP_CLEAR) begin
							state_q <= ST_CLR;
						end else if (in_err) begin
							state_q <= ST_DONE;
						end else if (req.opcode == OP_ADD) begin
							state_q <= (req.amount == '0) ? ST_DONE : ST_UPD;
						end else begin
							state_q <= ST_WALK_A;
						end
					end
				end
				ST_WALK_A: begin
					if (node_dn == '0) begin
						node_q  <= start_b;
						state_q <= (start_b == '0) ? ST_DRAIN : ST_WALK_B;
					end else begin
						node_q <= node_dn;
					end
				end
				ST_WALK_B: begin
					node_q <= node_dn;
					if (node_dn == '0) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= (req_q.opcode == OP_QUERY) ? ST_DONE : ST_CALC;
				end
				ST_CALC: begin
					node_q  <= start_a;
					state_q <= (diff == '0) ? ST_DONE : ST_UPD;
				end
				ST_UPD: begin
					if (upd_live) begin
						node_q <= node_up;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= item_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						item_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		neg_s1   <= state_q == ST_WALK_B;
		waddr_s1 <= rd_addr;
		if (pend_s1) begin
			acc_q <= neg_s1 ? acc_q - rd_data : acc_q + rd_data;
		end
		if (state_q == ST_CALC) begin
			delta_q <= diff;
		end
		if (start && (state_q == ST_IDLE)) begin
			req_q   <= req;
			err_q   <= in_err && (req.opcode != OP_CLEAR);
			acc_q   <= '0;
			delta_q <= DATA_W'(req.amount);
		end
	end

endmodule
